### sv/orom_pkg.sv
// shared types and constants for the opaque region outline marker
package orom_pkg;

    localparam int SIDE_W = 11;
    localparam int COORD_W = 16;
    localparam int ALPHA_W = 8;
    localparam int DATA_W = 16;
    localparam int REG_IDX_W = 2;
    localparam int MIN_SIDE = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int WIN_W = 9;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 2'd3;

    localparam logic KIND_PIXEL = 1'b0;

    // window neighbors, center excluded
    localparam logic [WIN_W-1:0] WIN_MASK = 9'h1EF;

    typedef struct packed {
        logic opaque;
        logic src;
        logic emit;
        logic done;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_item;

endpackage

### sv/orom_front.sv
// front end: configuration registers, raster counters and pixel classification
module orom_front #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wen,
    input  logic [orom_pkg::REG_IDX_W-1:0]       i_cfg_index,
    input  logic [orom_pkg::DATA_W-1:0]          i_cfg_wdata,
    input  logic                                 i_in_valid,
    input  logic                                 i_kind,
    input  logic [orom_pkg::ALPHA_W-1:0]         i_alpha,
    input  logic                                 i_full,
    output logic                                 o_push,
    output logic [$clog2(MAX_SIDE)-1:0]          o_push_idx,
    output orom_pkg::t_item                      o_push_item
);
    import orom_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);
    localparam int CXW = ((CW > SIDE_W) ? CW : SIDE_W) + 1;

    logic [SIDE_W-1:0] r_w;
    logic [SIDE_W-1:0] r_h;
    logic signed [COORD_W-1:0] r_ox;
    logic signed [COORD_W-1:0] r_oy;
    logic [CW-1:0] r_col;
    logic [SIDE_W-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [SIDE_W-1:0] n_row;

    logic [CXW-1:0] col_x;
    logic [CXW-1:0] row_x;
    logic [CXW-1:0] w_x;
    logic [CXW-1:0] h_x;
    logic [CXW-1:0] dc;
    logic opaque;
    logic inner;
    logic emit;
    logic done;
    logic accept;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = v;
        if (v < SIDE_W'(MIN_SIDE)) begin
            r = SIDE_W'(MIN_SIDE);
        end else if (int'(v) > MAX_SIDE) begin
            r = SIDE_W'(MAX_SIDE);
        end
        return r;
    endfunction

    always_comb begin
        col_x = CXW'(r_col);
        row_x = CXW'(r_row);
        w_x = CXW'(r_w);
        h_x = CXW'(r_h);
        opaque = (i_kind == KIND_PIXEL) && (i_alpha != '0);
        inner = (r_row != '0) && (row_x + CXW'(2) <= h_x)
            && (r_col != '0) && (col_x + CXW'(2) <= w_x);
        emit = (r_row >= SIDE_W'(2)) || ((r_row == SIDE_W'(1)) && (r_col != '0));
        done = row_x >= h_x + CXW'(1);
        dc = (r_col == '0) ? (w_x - CXW'(1)) : (col_x - CXW'(1));
        accept = i_in_valid && !i_full;

        o_push = accept;
        o_push_idx = r_col;
        o_push_item.opaque = opaque;
        o_push_item.src = opaque && inner;
        o_push_item.emit = emit;
        o_push_item.done = done;
        o_push_item.x = r_ox + COORD_W'(dc);
        o_push_item.y = r_oy + COORD_W'(r_row)
            - ((r_col == '0) ? COORD_W'(2) : COORD_W'(1));

        n_col = r_col;
        n_row = r_row;
        if (emit && done) begin
            n_col = '0;
            n_row = '0;
        end else if (col_x + CXW'(1) >= w_x) begin
            n_col = '0;
            n_row = r_row + SIDE_W'(1);
        end else begin
            n_col = CW'(col_x + CXW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= SIDE_W'(MIN_SIDE);
            r_h <= SIDE_W'(MIN_SIDE);
            r_ox <= '0;
            r_oy <= '0;
            r_col <= '0;
            r_row <= '0;
        end else begin
            if (i_cfg_wen) begin
                unique case (i_cfg_index)
                    REG_FRAME_WIDTH: r_w <= clamp_side(i_cfg_wdata[SIDE_W-1:0]);
                    REG_FRAME_HEIGHT: r_h <= clamp_side(i_cfg_wdata[SIDE_W-1:0]);
                    REG_ORIGIN_X: r_ox <= signed'(i_cfg_wdata);
                    REG_ORIGIN_Y: r_oy <= signed'(i_cfg_wdata);
                    default: ;
                endcase
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

endmodule

### sv/orom_queue.sv
// short request queue between front and back end
module orom_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import orom_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;
    logic do_push;
    logic do_pop;

    always_comb begin
        o_full = r_count == NW'(QUEUE_DEPTH);
        o_valid = r_count != '0;
        o_data = r_mem[r_rd_ptr];
        do_push = i_push && !o_full;
        do_pop = i_pop && o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + NW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

endmodule

### sv/orom_back.sv
// back end: line stores, 3x3 window, mark decision and output register
module orom_back #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  logic [$clog2(MAX_SIDE)-1:0]          i_q_idx,
    input  orom_pkg::t_item                      i_q_item,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [orom_pkg::COORD_W-1:0]  o_pixel_x,
    output logic signed [orom_pkg::COORD_W-1:0]  o_pixel_y,
    output logic                                 o_outline_mark,
    output logic                                 o_frame_done
);
    import orom_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);
    localparam int FW = CW + 1;

    // bit 0: last row's source flag, bit 1: the row above that
    logic [1:0] r_src_mem [MAX_SIDE];
    logic r_zero_mem [MAX_SIDE];

    logic r_s2_valid;
    logic [CW-1:0] r_s2_idx;
    t_item r_s2_item;
    logic [1:0] r_rd_src;
    logic r_rd_z;
    logic r_hit;
    logic r_filled;
    logic [1:0] r_fwd_src;
    logic r_fwd_z;
    logic [FW-1:0] r_fill;
    logic [WIN_W-1:0] r_win;
    logic r_az;

    logic r_out_valid;
    logic signed [COORD_W-1:0] r_out_x;
    logic signed [COORD_W-1:0] r_out_y;
    logic r_out_mark;
    logic r_out_done;

    logic go;
    logic wr_en;
    logic [1:0] src_eff;
    logic z_eff;
    logic up1;
    logic up2;
    logic [1:0] wr_src;
    logic wr_z;
    logic [WIN_W-1:0] n_win;
    logic mark;

    always_comb begin
        go = !r_out_valid || !i_out_stall;
        o_pop = go && i_q_valid;
        wr_en = go && r_s2_valid;
        src_eff = r_hit ? r_fwd_src : (r_filled ? r_rd_src : 2'b00);
        z_eff = r_hit ? r_fwd_z : r_rd_z;
        up1 = src_eff[0];
        up2 = src_eff[1];
        wr_src = {up1, r_s2_item.src};
        wr_z = !r_s2_item.opaque;
        n_win = {r_s2_item.src, up1, up2, r_win[WIN_W-1:3]};
        mark = r_az && ((n_win & WIN_MASK) != '0);
        o_out_valid = r_out_valid;
        o_pixel_x = r_out_x;
        o_pixel_y = r_out_y;
        o_outline_mark = r_out_mark;
        o_frame_done = r_out_done;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_src_mem[r_s2_idx] <= wr_src;
            r_zero_mem[r_s2_idx] <= wr_z;
        end
        if (go) begin
            r_rd_src <= r_src_mem[i_q_idx];
            r_rd_z <= r_zero_mem[i_q_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_s2_idx <= i_q_idx;
            r_s2_item <= i_q_item;
            r_fwd_src <= wr_src;
            r_fwd_z <= wr_z;
            r_hit <= r_s2_valid && (r_s2_idx == i_q_idx);
            r_filled <= FW'(i_q_idx) < r_fill;
            r_out_x <= r_s2_item.x;
            r_out_y <= r_s2_item.y;
            r_out_mark <= mark;
            r_out_done <= r_s2_item.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_fill <= '0;
            r_win <= '0;
            r_az <= 1'b0;
        end else begin
            if (go) begin
                r_s2_valid <= i_q_valid;
                r_out_valid <= r_s2_valid && r_s2_item.emit;
            end
            if (wr_en) begin
                r_win <= n_win;
                r_az <= z_eff;
                if (FW'(r_s2_idx) == r_fill) begin
                    r_fill <= r_fill + FW'(1);
                end
            end
        end
    end

endmodule

### sv/opaque_region_outline_marker_core.sv
// top level of the opaque region outline marker
// Sustains one request per clock unless the output stalls: the front end
// classifies each pixel and tracks the raster position, a four-entry queue
// decouples it from the back end, whose line stores each have one read and
// one write port, used once per request. A decision comes out frame_width+1
// requests after its pixel, so a frame of frame_width*frame_height pixels
// needs frame_width+1 drain requests. An accepted request passes from the
// queue through the s2 register to the result register. Line stores need no
// clearing after reset; a fill count tracks which entries have been written.
module opaque_region_outline_marker_core #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wen,
    input  logic [orom_pkg::REG_IDX_W-1:0]       i_cfg_index,
    input  logic [orom_pkg::DATA_W-1:0]          i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_kind,
    input  logic [orom_pkg::ALPHA_W-1:0]         i_alpha,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [orom_pkg::COORD_W-1:0]  o_pixel_x,
    output logic signed [orom_pkg::COORD_W-1:0]  o_pixel_y,
    output logic                                 o_outline_mark,
    output logic                                 o_frame_done
);
    import orom_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);
    localparam int QW = CW + $bits(t_item);

    logic q_full;
    logic q_valid;
    logic q_pop;
    logic push;
    logic [CW-1:0] push_idx;
    t_item push_item;
    logic [QW-1:0] q_data;
    logic [CW-1:0] q_idx;
    t_item q_item;

    assign o_in_stall = q_full;
    assign q_idx = q_data[QW-1 -: CW];
    assign q_item = t_item'(q_data[$bits(t_item)-1:0]);

    orom_front #(
        .MAX_SIDE(MAX_SIDE)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid),
        .i_kind(i_kind),
        .i_alpha(i_alpha),
        .i_full(q_full),
        .o_push(push),
        .o_push_idx(push_idx),
        .o_push_item(push_item)
    );

    orom_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_data({push_idx, push_item}),
        .i_pop(q_pop),
        .o_full(q_full),
        .o_valid(q_valid),
        .o_data(q_data)
    );

    orom_back #(
        .MAX_SIDE(MAX_SIDE)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_q_valid(q_valid),
        .i_q_idx(q_idx),
        .i_q_item(q_item),
        .o_pop(q_pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_pixel_x(o_pixel_x),
        .o_pixel_y(o_pixel_y),
        .o_outline_mark(o_outline_mark),
        .o_frame_done(o_frame_done)
    );

endmodule

### sv/orom_checker.sv
// port checks for the opaque region outline marker, bound to the top level
module orom_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [orom_pkg::COORD_W-1:0]  o_pixel_x,
    input logic signed [orom_pkg::COORD_W-1:0]  o_pixel_y,
    input logic                                 o_outline_mark,
    input logic                                 o_frame_done
);

    // a result waiting on a stall stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_pixel_x) && $stable(o_pixel_y)
            && $stable(o_outline_mark) && $stable(o_frame_done)))
        else $error("stalled result changed");

    // reset empties the result register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

    // reset empties the request queue
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind opaque_region_outline_marker_core orom_checker u_orom_checker (.*);
